>>> src/rbft_pkg.sv
`default_nettype none
package rbft_pkg;

	localparam int VEC_BITS_DEF  = 21;
	localparam int QUAT_FRAC_DEF = 14;
	localparam int UNIT_BITS     = 30;
	localparam int VEC_FRAC      = 10;
	localparam int QW            = 18;
	localparam int OFFW          = 21;
	localparam int UW            = 32;
	localparam int SQRT_STEPS    = 32;
	localparam int DIV_STEPS     = 31;
	localparam int UNIT_LAT      = 3 + SQRT_STEPS + 1 + DIV_STEPS;
	localparam int QUEUE_DEPTH   = 4;
	localparam int CFG_IDXW      = 3;
	localparam int CFG_DATAW     = 21;

	localparam logic [CFG_IDXW-1:0] REG_ROT_W = 3'd0;
	localparam logic [CFG_IDXW-1:0] REG_ROT_X = 3'd1;
	localparam logic [CFG_IDXW-1:0] REG_ROT_Y = 3'd2;
	localparam logic [CFG_IDXW-1:0] REG_ROT_Z = 3'd3;
	localparam logic [CFG_IDXW-1:0] REG_OFF_X = 3'd4;
	localparam logic [CFG_IDXW-1:0] REG_OFF_Y = 3'd5;
	localparam logic [CFG_IDXW-1:0] REG_OFF_Z = 3'd6;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_PARENT_ZERO = 2'd1,
		ST_MOUNT_ZERO  = 2'd2
	} status_t;

	typedef logic [3:0][UW-1:0] uquat_t;

	typedef struct packed {
		logic [QW-1:0] qw;
		logic [QW-1:0] qx;
		logic [QW-1:0] qy;
		logic [QW-1:0] qz;
		logic [62:0]   pos;
		logic [62:0]   vel;
		logic [62:0]   rate;
	} in_item_t;

	typedef struct packed {
		uquat_t      pu;
		uquat_t      mu;
		status_t     status;
		logic [62:0] pos;
		logic [62:0] vel;
		logic [62:0] rate;
	} fb_t;

	typedef struct packed {
		logic [3:0][15:0] cq;
		logic [62:0]      pos;
		logic [62:0]      vel;
		logic [62:0]      rate;
		status_t          status;
	} out_item_t;

	// round to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] x,
			input int unsigned s);
		logic [63:0] m;
		logic [63:0] r;
		m = x[63] ? 64'(-x) : 64'(x);
		r = (m + (64'd1 << (s - 1))) >> s;
		return x[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [63:0] clamp64(input logic signed [63:0] x,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		return (x < lo) ? lo : ((x > hi) ? hi : x);
	endfunction

endpackage
`default_nettype wire

>>> src/rbft_unit.sv
`default_nettype none
module rbft_unit #(
	parameter int CW = 18
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [3:0][CW-1:0]    c,
	output rbft_pkg::uquat_t           u,
	output logic                       zero
);
	import rbft_pkg::*;

	localparam int SQW = 2 * CW;

	logic [3:0][CW-1:0]  mag_c;
	logic [3:0][SQW-1:0] sq_c;
	logic [3:0][CW-1:0]  mag_s1, mag_s2;
	logic [3:0]          neg_s1, neg_s2;
	logic [3:0][SQW-1:0] sq_s1;
	logic [63:0]         sum_s2;
	logic [3:0]          tc;

	// sqrt pipe, index 0 is the shift stage
	logic [63:0]        sv   [0:SQRT_STEPS];
	logic [63:0]        sr   [0:SQRT_STEPS];
	logic [3:0]         st   [0:SQRT_STEPS];
	logic               sz   [0:SQRT_STEPS];
	logic [3:0][CW-1:0] smag [0:SQRT_STEPS];
	logic [3:0]         sneg [0:SQRT_STEPS];

	// divide pipe, index 0 holds numerators
	logic [3:0][32:0]   drem [0:DIV_STEPS];
	logic [3:0][30:0]   dlow [0:DIV_STEPS];
	logic [3:0][30:0]   dq   [0:DIV_STEPS];
	logic [31:0]        dd   [0:DIV_STEPS];
	logic               dz   [0:DIV_STEPS];
	logic [3:0]         dneg [0:DIV_STEPS];

	logic [31:0]        nn;
	logic [3:0][63:0]   num_c;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = c[i][CW-1] ? CW'(-c[i]) : c[i];
			sq_c[i]  = SQW'(mag_c[i]) * SQW'(mag_c[i]);
		end
	end

	always_comb begin
		tc = '0;
		for (int k = 0; k < 15; k++)
			if (sum_s2 < (64'd1 << (60 - 2 * k)))
				tc = tc + 4'd1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag_c;
			sq_s1   <= sq_c;
			for (int i = 0; i < 4; i++)
				neg_s1[i] <= c[i][CW-1];
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			sum_s2  <= 64'(sq_s1[0]) + 64'(sq_s1[1]) + 64'(sq_s1[2]) + 64'(sq_s1[3]);
			sv[0]   <= sum_s2 << {tc, 1'b0};
			sr[0]   <= '0;
			st[0]   <= tc;
			sz[0]   <= (sum_s2 == '0);
			smag[0] <= mag_s2;
			sneg[0] <= neg_s2;
		end
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] trial, vn, rn;
		always_comb begin
			trial = sr[k] + BIT;
			if (sv[k] >= trial) begin
				vn = sv[k] - trial;
				rn = (sr[k] >> 1) + BIT;
			end else begin
				vn = sv[k];
				rn = sr[k] >> 1;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sv[k+1]   <= vn;
				sr[k+1]   <= rn;
				st[k+1]   <= st[k];
				sz[k+1]   <= sz[k];
				smag[k+1] <= smag[k];
				sneg[k+1] <= sneg[k];
			end
		end
	end

	always_comb begin
		nn = (sr[SQRT_STEPS][31:0] == '0) ? 32'd1 : sr[SQRT_STEPS][31:0];
		for (int i = 0; i < 4; i++)
			num_c[i] = (64'(smag[SQRT_STEPS][i]) << (UNIT_BITS + 32'(st[SQRT_STEPS])))
				+ 64'(nn >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				drem[0][i] <= num_c[i][63:31];
				dlow[0][i] <= num_c[i][30:0];
			end
			dq[0]   <= '0;
			dd[0]   <= nn;
			dz[0]   <= sz[SQRT_STEPS];
			dneg[0] <= sneg[SQRT_STEPS];
		end
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int BP = DIV_STEPS - 1 - k;
		logic [3:0][32:0] rs, rn;
		logic [3:0][30:0] qn;
		always_comb begin
			for (int i = 0; i < 4; i++) begin
				rs[i] = {drem[k][i][31:0], dlow[k][i][BP]};
				qn[i] = dq[k][i];
				if (rs[i] >= {1'b0, dd[k]}) begin
					rn[i]     = rs[i] - {1'b0, dd[k]};
					qn[i][BP] = 1'b1;
				end else begin
					rn[i] = rs[i];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				drem[k+1] <= rn;
				dq[k+1]   <= qn;
				dlow[k+1] <= dlow[k];
				dd[k+1]   <= dd[k];
				dz[k+1]   <= dz[k];
				dneg[k+1] <= dneg[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			u[i] = dneg[DIV_STEPS][i] ? UW'(-{1'b0, dq[DIV_STEPS][i]})
				: UW'({1'b0, dq[DIV_STEPS][i]});
		zero = dz[DIV_STEPS];
	end

endmodule
`default_nettype wire

>>> src/rbft_front.sv
`default_nettype none
module rbft_front (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire rbft_pkg::in_item_t       in_item,
	input  wire logic [3:0][17:0]         mount_rot,
	input  wire logic                     q_full,
	output logic                          push,
	output rbft_pkg::fb_t                 push_item
);
	import rbft_pkg::*;

	typedef struct packed {
		logic [62:0] pos;
		logic [62:0] vel;
		logic [62:0] rate;
	} vecs_t;

	logic               en;
	logic [3:0][QW-1:0] pc;
	uquat_t             pu, mu;
	logic               pzero, mzero;
	logic               vl_q [1:UNIT_LAT];
	vecs_t              pl_s [1:UNIT_LAT];

	assign en       = !q_full;
	assign in_ready = en;

	assign pc[0] = in_item.qw;
	assign pc[1] = in_item.qx;
	assign pc[2] = in_item.qy;
	assign pc[3] = in_item.qz;

	rbft_unit #(.CW(QW)) u_parent (
		.clk  (clk),
		.en   (en),
		.c    (pc),
		.u    (pu),
		.zero (pzero)
	);

	rbft_unit #(.CW(QW)) u_mount (
		.clk  (clk),
		.en   (en),
		.c    (mount_rot),
		.u    (mu),
		.zero (mzero)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= UNIT_LAT; k++)
				vl_q[k] <= 1'b0;
		end else if (en) begin
			vl_q[1] <= in_valid;
			for (int k = 2; k <= UNIT_LAT; k++)
				vl_q[k] <= vl_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s[1] <= '{pos: in_item.pos, vel: in_item.vel, rate: in_item.rate};
			for (int k = 2; k <= UNIT_LAT; k++)
				pl_s[k] <= pl_s[k-1];
		end
	end

	always_comb begin
		push             = vl_q[UNIT_LAT] && en;
		push_item.pu     = pu;
		push_item.mu     = mu;
		push_item.pos    = pl_s[UNIT_LAT].pos;
		push_item.vel    = pl_s[UNIT_LAT].vel;
		push_item.rate   = pl_s[UNIT_LAT].rate;
		if (pzero)
			push_item.status = ST_PARENT_ZERO;
		else if (mzero)
			push_item.status = ST_MOUNT_ZERO;
		else
			push_item.status = ST_OK;
	end

endmodule
`default_nettype wire

>>> src/rbft_queue.sv
`default_nettype none
module rbft_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rbft_pkg::fb_t push_item,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output rbft_pkg::fb_t      head
);
	import rbft_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	fb_t         mem [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count lost a request");

endmodule
`default_nettype wire

>>> src/rbft_back.sv
`default_nettype none
module rbft_back #(
	parameter int VEC_COMPONENT_BITS = rbft_pkg::VEC_BITS_DEF,
	parameter int QUAT_FRAC_BITS     = rbft_pkg::QUAT_FRAC_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rbft_pkg::fb_t       head,
	input  wire logic                q_empty,
	output logic                     pop,
	input  wire logic [2:0][20:0]    mount_off,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output rbft_pkg::out_item_t      out_item
);
	import rbft_pkg::*;

	localparam int VB = VEC_COMPONENT_BITS;
	localparam int D  = UNIT_LAT - 2;
	localparam logic signed [63:0] VHI  = (64'sd1 <<< (VB - 1)) - 64'sd1;
	localparam logic signed [63:0] VLO  = -VHI - 64'sd1;
	localparam logic signed [63:0] QLIM = 64'sd1 <<< QUAT_FRAC_BITS;
	localparam logic signed [63:0] ULIM = 64'sd1 <<< UNIT_BITS;
	localparam logic signed [63:0] ONE  = 64'sd1 <<< (2 * UNIT_BITS);

	typedef logic [8:0][63:0]      p9_t;
	typedef logic [2:0][2:0][31:0] mat_t;
	typedef logic [2:0][2:0][63:0] prod33_t;

	typedef struct packed {
		status_t     status;
		logic [62:0] pos;
		logic [62:0] vel;
		logic [62:0] rate;
	} res_t;

	function automatic logic signed [63:0] vcomp(input logic [62:0] p, input int i);
		logic [VB-1:0] f;
		f = p[VB*i +: VB];
		return 64'($signed(f));
	endfunction

	function automatic p9_t mprods(input uquat_t q);
		p9_t p;
		p[0] = $signed(q[1]) * $signed(q[1]);
		p[1] = $signed(q[2]) * $signed(q[2]);
		p[2] = $signed(q[3]) * $signed(q[3]);
		p[3] = $signed(q[1]) * $signed(q[2]);
		p[4] = $signed(q[1]) * $signed(q[3]);
		p[5] = $signed(q[2]) * $signed(q[3]);
		p[6] = $signed(q[0]) * $signed(q[1]);
		p[7] = $signed(q[0]) * $signed(q[2]);
		p[8] = $signed(q[0]) * $signed(q[3]);
		return p;
	endfunction

	function automatic logic [31:0] ent(input logic signed [63:0] x);
		logic signed [63:0] r;
		r = clamp64(rnd_shift(x, UNIT_BITS), -ULIM, ULIM);
		return r[31:0];
	endfunction

	function automatic mat_t mbuild(input p9_t p);
		mat_t m;
		logic signed [63:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
		xx = $signed(p[0]); yy = $signed(p[1]); zz = $signed(p[2]);
		xy = $signed(p[3]); xz = $signed(p[4]); yz = $signed(p[5]);
		wx = $signed(p[6]); wy = $signed(p[7]); wz = $signed(p[8]);
		m[0][0] = ent(ONE - 2 * (yy + zz));
		m[0][1] = ent(2 * (xy - wz));
		m[0][2] = ent(2 * (xz + wy));
		m[1][0] = ent(2 * (xy + wz));
		m[1][1] = ent(ONE - 2 * (xx + zz));
		m[1][2] = ent(2 * (yz - wx));
		m[2][0] = ent(2 * (xz - wy));
		m[2][1] = ent(2 * (yz + wx));
		m[2][2] = ent(ONE - 2 * (xx + yy));
		return m;
	endfunction

	logic en;

	// stage 1
	logic               v_s1;
	logic [3:0][3:0][63:0] qm_s1;
	p9_t                pp_s1, mp_s1;
	logic [5:0][63:0]   lp_s1;
	res_t               r_s1;
	// stage 2
	logic               v_s2;
	logic [3:0][31:0]   prod_s2;
	mat_t               rp_s2, rm_s2;
	logic [2:0][32:0]   lev_s2;
	res_t               r_s2;
	// stage 3
	logic               v_s3;
	prod33_t            po_s3, pl_s3, pr_s3;
	res_t               r_s3;
	// stage 4 and delay line
	logic               dv_q [4:4+D];
	res_t               dr_s [4:4+D];

	logic [3:0][63:0]   qm_c [4];
	logic signed [63:0] rv [3];
	logic signed [63:0] ov [3];
	logic signed [63:0] rs [4];
	prod33_t            po_c, pl_c, pr_c;
	logic [62:0]        cpos_c, cvel_c, crate_c;
	uquat_t             cu;
	logic               cz;
	out_item_t          fin_c;
	logic signed [63:0] lv [3];
	logic signed [63:0] sp, sv, sr, cp;

	assign en  = !out_valid || out_ready;
	assign pop = en && !q_empty;

	always_comb begin
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				qm_c[i][j] = $signed(head.pu[i]) * $signed(head.mu[j]);
		for (int k = 0; k < 3; k++) begin
			rv[k] = vcomp(head.rate, k);
			ov[k] = 64'($signed(mount_off[k]));
		end
	end

	always_comb begin
		rs[0] = $signed(qm_s1[0][0]) - $signed(qm_s1[1][1]) - $signed(qm_s1[2][2])
			- $signed(qm_s1[3][3]);
		rs[1] = $signed(qm_s1[0][1]) + $signed(qm_s1[1][0]) + $signed(qm_s1[2][3])
			- $signed(qm_s1[3][2]);
		rs[2] = $signed(qm_s1[0][2]) - $signed(qm_s1[1][3]) + $signed(qm_s1[2][0])
			+ $signed(qm_s1[3][1]);
		rs[3] = $signed(qm_s1[0][3]) + $signed(qm_s1[1][2]) - $signed(qm_s1[2][1])
			+ $signed(qm_s1[3][0]);
		lv[0] = rnd_shift($signed(lp_s1[0]) - $signed(lp_s1[1]), VEC_FRAC);
		lv[1] = rnd_shift($signed(lp_s1[2]) - $signed(lp_s1[3]), VEC_FRAC);
		lv[2] = rnd_shift($signed(lp_s1[4]) - $signed(lp_s1[5]), VEC_FRAC);
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				po_c[i][j] = $signed(rp_s2[i][j]) * 64'($signed(mount_off[j]));
				pl_c[i][j] = $signed(rp_s2[i][j]) * 64'($signed(lev_s2[j]));
				pr_c[i][j] = $signed(rm_s2[j][i]) * vcomp(r_s2.rate, j);
			end
	end

	always_comb begin
		cpos_c  = '0;
		cvel_c  = '0;
		crate_c = '0;
		for (int i = 0; i < 3; i++) begin
			sp = rnd_shift($signed(po_s3[i][0]) + $signed(po_s3[i][1])
				+ $signed(po_s3[i][2]), UNIT_BITS) + vcomp(r_s3.pos, i);
			sv = rnd_shift($signed(pl_s3[i][0]) + $signed(pl_s3[i][1])
				+ $signed(pl_s3[i][2]), UNIT_BITS) + vcomp(r_s3.vel, i);
			sr = rnd_shift($signed(pr_s3[i][0]) + $signed(pr_s3[i][1])
				+ $signed(pr_s3[i][2]), UNIT_BITS);
			cpos_c[VB*i +: VB]  = VB'(clamp64(sp, VLO, VHI));
			cvel_c[VB*i +: VB]  = VB'(clamp64(sv, VLO, VHI));
			crate_c[VB*i +: VB] = VB'(clamp64(sr, VLO, VHI));
		end
	end

	rbft_unit #(.CW(UW)) u_prod (
		.clk  (clk),
		.en   (en),
		.c    (prod_s2),
		.u    (cu),
		.zero (cz)
	);

	always_comb begin
		cp    = '0;
		fin_c = '0;
		if (dr_s[4+D].status == ST_OK) begin
			fin_c.pos  = dr_s[4+D].pos;
			fin_c.vel  = dr_s[4+D].vel;
			fin_c.rate = dr_s[4+D].rate;
			for (int i = 0; i < 4; i++) begin
				cp = cz ? 64'sd0 : 64'($signed(cu[i]));
				cp = rnd_shift(cp, UNIT_BITS - QUAT_FRAC_BITS);
				cp = clamp64(clamp64(cp, -QLIM, QLIM), -64'sd32768, 64'sd32767);
				fin_c.cq[i] = cp[15:0];
			end
		end
		fin_c.status = dr_s[4+D].status;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			for (int k = 4; k <= 4 + D; k++)
				dv_q[k] <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1    <= pop;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			dv_q[4] <= v_s3;
			for (int k = 5; k <= 4 + D; k++)
				dv_q[k] <= dv_q[k-1];
			out_valid <= dv_q[4+D];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++)
				qm_s1[i] <= qm_c[i];
			pp_s1    <= mprods(head.pu);
			mp_s1    <= mprods(head.mu);
			lp_s1[0] <= rv[1] * ov[2];
			lp_s1[1] <= rv[2] * ov[1];
			lp_s1[2] <= rv[2] * ov[0];
			lp_s1[3] <= rv[0] * ov[2];
			lp_s1[4] <= rv[0] * ov[1];
			lp_s1[5] <= rv[1] * ov[0];
			r_s1     <= '{status: head.status, pos: head.pos, vel: head.vel,
				rate: head.rate};

			for (int i = 0; i < 4; i++)
				prod_s2[i] <= 32'(rnd_shift(rs[i], UNIT_BITS));
			rp_s2 <= mbuild(pp_s1);
			rm_s2 <= mbuild(mp_s1);
			for (int k = 0; k < 3; k++)
				lev_s2[k] <= lv[k][32:0];
			r_s2 <= r_s1;

			po_s3 <= po_c;
			pl_s3 <= pl_c;
			pr_s3 <= pr_c;
			r_s3  <= r_s2;

			dr_s[4] <= '{status: r_s3.status, pos: cpos_c, vel: cvel_c, rate: crate_c};
			for (int k = 5; k <= 4 + D; k++)
				dr_s[k] <= dr_s[k-1];

			out_item <= fin_c;
		end
	end

endmodule
`default_nettype wire

>>> src/rigid_body_frame_transform_unit.sv
// Rigid-body frame transform.
// Input stream s_*: one parent state per request (quaternion, position,
// velocity, body rate). Output stream m_*: the child state in the mounted
// frame plus a status code in m_tuser (0 ok, 1 parent quaternion zero,
// 2 mounting quaternion zero; on error all other fields are zero).
// The mounting rotation and offset are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while no request is in flight, as the
// block does not enforce it. Throughput: one request per cycle while s_tready
// is high. Latency from input acceptance to m_tvalid is set by the two
// normalization pipelines in series (32-step square root, 31-step divider
// each), one in the front end (a unit each for the parent and mounting
// quaternions) and one in the back end for the product quaternion.
// A 4-entry queue splits front and back. When the receiver stalls, the back
// end holds; the front end keeps accepting until the queue fills, then
// s_tready drops.
// Reset clears all valid state and loads the identity mounting rotation
// with zero offset.
`default_nettype none
module rigid_body_frame_transform_unit #(
	parameter int VEC_COMPONENT_BITS = rbft_pkg::VEC_BITS_DEF,
	parameter int QUAT_FRAC_BITS     = rbft_pkg::QUAT_FRAC_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// qw, qx, qy, qz (18 each), parent_position, parent_velocity, parent_rate (63 each)
	input  wire logic [263:0]                   s_tdata,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// child_qw, qx, qy, qz (16 each), child_position, velocity, rate (63 each)
	output logic [255:0]                        m_tdata,
	// status
	output logic [1:0]                          m_tuser,
	input  wire logic                           cfg_we,
	input  wire logic [rbft_pkg::CFG_IDXW-1:0]  cfg_index,
	input  wire logic [rbft_pkg::CFG_DATAW-1:0] cfg_data
);
	import rbft_pkg::*;

	logic [3:0][QW-1:0]   rot_q;
	logic [2:0][OFFW-1:0] off_q;
	in_item_t             in_item;
	fb_t                  push_item, head;
	logic                 push, pop, q_full, q_empty;
	out_item_t            out_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= QW'(16384);
			rot_q[1] <= '0;
			rot_q[2] <= '0;
			rot_q[3] <= '0;
			off_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROT_W: rot_q[0] <= cfg_data[QW-1:0];
				REG_ROT_X: rot_q[1] <= cfg_data[QW-1:0];
				REG_ROT_Y: rot_q[2] <= cfg_data[QW-1:0];
				REG_ROT_Z: rot_q[3] <= cfg_data[QW-1:0];
				REG_OFF_X: off_q[0] <= cfg_data[OFFW-1:0];
				REG_OFF_Y: off_q[1] <= cfg_data[OFFW-1:0];
				REG_OFF_Z: off_q[2] <= cfg_data[OFFW-1:0];
				default: ;
			endcase
		end
	end

	assign in_item.qw   = s_tdata[17:0];
	assign in_item.qx   = s_tdata[35:18];
	assign in_item.qy   = s_tdata[53:36];
	assign in_item.qz   = s_tdata[71:54];
	assign in_item.pos  = s_tdata[134:72];
	assign in_item.vel  = s_tdata[197:135];
	assign in_item.rate = s_tdata[260:198];

	rbft_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.mount_rot (rot_q),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rbft_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (head)
	);

	rbft_back #(
		.VEC_COMPONENT_BITS (VEC_COMPONENT_BITS),
		.QUAT_FRAC_BITS     (QUAT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_empty),
		.pop       (pop),
		.mount_off (off_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = {3'b000, out_item.rate, out_item.vel, out_item.pos,
		out_item.cq[3], out_item.cq[2], out_item.cq[1], out_item.cq[0]};
	assign m_tuser = out_item.status;

endmodule
`default_nettype wire
